FILE: sv/thac_pkg.sv
`timescale 1ns / 1ps
package thac_pkg;

  localparam int LN_TABLE_ENTRIES_DEF = 64;
  localparam int TEMP_SCALE_DEF       = 500;

  // fixed-point widths
  localparam int LN_W      = 25;   // Q5.20 signed log
  localparam int LN_FRAC_W = 20;   // table entries, Q20 unsigned

  // output saturation limits
  localparam logic signed [17:0] TEMP_MAX = 18'sh1FFFF;
  localparam logic signed [17:0] TEMP_MIN = 18'sh20000;

  // 100 * 2^32, numerator of 1/T0
  localparam logic [38:0] INV_T0_NUM = 39'd100 << 32;

  // x / 100 == (x * RECIP100) >> RECIP100_SHIFT, exact for x < 2^30
  localparam logic [26:0] RECIP100       = 27'd85899346;
  localparam int          RECIP100_SHIFT = 33;

  // register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_TC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER   = 3'd5;

  localparam logic [13:0] BETA_RST    = 14'd3950;
  localparam logic [15:0] FULL_RST    = 16'd4095;
  localparam logic [15:0] ZERO_CK_RST = 16'd27315;
  localparam logic [14:0] REF_TC_RST  = 15'd2500;
  localparam logic [19:0] NOMINAL_RST = 20'd10000;
  localparam logic [19:0] DIVIDER_RST = 20'd10000;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_OPEN = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  // shift-subtract divide, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + n/nn) in Q20, rounded, via 2*atanh(n/(2nn+n))
  function automatic logic [63:0] ln_entry(input logic [63:0] n, input logic [63:0] nn);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] term;
    logic [63:0] sum;
    u    = udiv64(n << 32, 64'd2 * nn + n);
    u2   = (u * u) >> 32;
    term = u;
    sum  = '0;
    for (int k = 0; k < 40; k++) begin
      sum  = sum + udiv64(term, 64'(2 * k + 1));
      term = (term * u2) >> 32;
    end
    return (64'd2 * sum + 64'd2048) >> 12;
  endfunction

endpackage

FILE: sv/thac_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage. Expects dividend < divisor * 2^WQ.
module thac_div #(
  parameter int WD = 32,
  parameter int WV = 16,
  parameter int WQ = 32,
  parameter int WS = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [WD-1:0] dividend,
  input  logic [WV-1:0] divisor,
  input  logic [WS-1:0] side_in,
  output logic          out_valid,
  output logic [WQ-1:0] quotient,
  output logic [WS-1:0] side_out
);

  logic          vld  [WQ];
  logic [WV-1:0] rem  [WQ];
  logic [WQ-1:0] low  [WQ];
  logic [WQ-1:0] quo  [WQ];
  logic [WV-1:0] dvs  [WQ];
  logic [WS-1:0] side [WQ];

  logic [WQ+WV-1:0] dext;
  assign dext = (WQ+WV)'(dividend);

  for (genvar k = 0; k < WQ; k++) begin : g_step
    logic          v_in;
    logic [WV-1:0] r_in;
    logic [WV-1:0] d_in;
    logic [WQ-1:0] l_in;
    logic [WQ-1:0] q_in;
    logic [WS-1:0] s_in;
    logic [WV:0]   trial;
    logic          fits;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = dext[WQ+WV-1:WQ];
      assign l_in = dext[WQ-1:0];
      assign q_in = '0;
      assign d_in = divisor;
      assign s_in = side_in;
    end else begin : g_next
      assign v_in = vld[k-1];
      assign r_in = rem[k-1];
      assign l_in = low[k-1];
      assign q_in = quo[k-1];
      assign d_in = dvs[k-1];
      assign s_in = side[k-1];
    end

    assign trial = {r_in, l_in[WQ-1]};
    assign fits  = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= fits ? WV'(trial - {1'b0, d_in}) : trial[WV-1:0];
        low[k]  <= l_in << 1;
        quo[k]  <= (q_in << 1) | WQ'(fits);
        dvs[k]  <= d_in;
        side[k] <= s_in;
      end
    end
  end

  assign out_valid = vld[WQ-1];
  assign quotient  = quo[WQ-1];
  assign side_out  = side[WQ-1];

endmodule

FILE: sv/thac_log.sv
`timescale 1ns / 1ps
// ln(q / 2^16) in Q5.20: leading-one search, normalize, table plus linear interpolation.
module thac_log
  import thac_pkg::*;
#(
  parameter int LN_TABLE_ENTRIES = LN_TABLE_ENTRIES_DEF,
  parameter int WS               = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [31:0]            q,
  input  logic [WS-1:0]          side_in,
  output logic                   out_valid,
  output logic signed [LN_W-1:0] ln,
  output logic [WS-1:0]          side_out
);

  localparam int IDX_W  = $clog2(LN_TABLE_ENTRIES);
  localparam int TAB_W  = $clog2(LN_TABLE_ENTRIES + 1);
  localparam int PROD_W = 31 + IDX_W;
  localparam logic [LN_FRAC_W-1:0] LN2 =
    LN_FRAC_W'(ln_entry(64'(LN_TABLE_ENTRIES), 64'(LN_TABLE_ENTRIES)));

  logic [LN_FRAC_W-1:0] ln_tab [LN_TABLE_ENTRIES+1];
  for (genvar i = 0; i <= LN_TABLE_ENTRIES; i++) begin : g_tab
    localparam logic [LN_FRAC_W-1:0] V =
      LN_FRAC_W'(ln_entry(64'(i), 64'(LN_TABLE_ENTRIES)));
    assign ln_tab[i] = V;
  end

  logic [5:0] vld;
  logic [WS-1:0] side [6];

  // stage 1: leading one
  logic [4:0]  msb;
  logic [31:0] q1;
  logic [4:0]  p1;
  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (q[i]) msb = 5'(i);
    end
  end

  // stage 2: normalized mantissa
  logic [31:0] shifted;
  logic [30:0] frac2;
  logic [4:0]  p2;
  assign shifted = q1 << (5'd31 - p1);

  // stage 3: table position
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  idx3;
  logic [30:0]       rem3;
  logic [4:0]        p3;
  assign prod = PROD_W'(frac2) * PROD_W'(LN_TABLE_ENTRIES);

  // stage 4: table lookup
  logic [TAB_W-1:0]     at;
  logic [LN_FRAC_W-1:0] lo4;
  logic [LN_FRAC_W-1:0] diff4;
  logic [30:0]          rem4;
  logic [4:0]           p4;
  assign at = TAB_W'(idx3);

  // stage 5: interpolation
  logic [LN_FRAC_W+30:0] ip_prod;
  logic [LN_FRAC_W-1:0]  lo5;
  logic [LN_FRAC_W-1:0]  ip5;
  logic [4:0]            p5;
  assign ip_prod = (LN_FRAC_W+31)'(diff4) * (LN_FRAC_W+31)'(rem4);

  // stage 6: add exponent term
  logic signed [LN_W-1:0] expo;
  logic signed [LN_W-1:0] ln_next;
  assign expo    = LN_W'($signed({1'b0, p5}) - 6'sd16);
  assign ln_next = expo * $signed(LN_W'(LN2)) + $signed(LN_W'(lo5)) + $signed(LN_W'(ip5));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int s = 1; s < 6; s++) side[s] <= side[s-1];
      q1    <= q;
      p1    <= msb;
      frac2 <= shifted[30:0];
      p2    <= p1;
      idx3  <= prod[PROD_W-1:31];
      rem3  <= prod[30:0];
      p3    <= p2;
      lo4   <= ln_tab[at];
      diff4 <= ln_tab[at + TAB_W'(1)] - ln_tab[at];
      rem4  <= rem3;
      p4    <= p3;
      lo5   <= lo4;
      ip5   <= ip_prod[LN_FRAC_W+30:31];
      p5    <= p4;
      ln    <= ln_next;
    end
  end

  assign out_valid = vld[5];
  assign side_out  = side[5];

endmodule

FILE: sv/thermistor_adc_to_celsius_core.sv
`timescale 1ns / 1ps
// NTC thermistor converter (beta equation). Each sample beat carries one ADC
// code and a channel tag; each result beat gives the temperature in 1/TEMP_SCALE
// degree Celsius (18 bit signed, saturated), the tag, and a status (ok, code
// zero, code at or above full scale). The pipeline takes one beat per clock
// while no result is stalled and holds 119 + TKN_W stages; nearly all of
// it is the four restoring dividers that retire one quotient bit per stage
// (1/T0, resistance ratio, ln/beta, final reciprocal). A stalled result
// freezes the whole pipeline in place. Registers are written through the cfg
// port (always ready) and must only change while the pipeline is empty.
module thermistor_adc_to_celsius_core
  import thac_pkg::*;
#(
  parameter int LN_TABLE_ENTRIES = LN_TABLE_ENTRIES_DEF,
  parameter int TEMP_SCALE       = TEMP_SCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // samples
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  logic [15:0]           adc_code,
  input  logic                  sensor_channel,
  // results
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic signed [17:0]    temp_scaled,
  output logic                  out_channel,
  output logic [1:0]            status
);

  // offset x = zck*TEMP_SCALE + 50, then /100 by reciprocal
  localparam int X_W   = 16 + $clog2(TEMP_SCALE + 1) + 1;
  localparam int XP_W  = X_W + 27;
  localparam int OFF_W = XP_W - RECIP100_SHIFT;
  // final dividend (TEMP_SCALE << 32) + iv/2
  localparam int TS_W  = 32 + $clog2(TEMP_SCALE + 1);
  localparam int TKN_W = ((TS_W > 39) ? TS_W : 39) + 1;
  localparam int IV_W  = 40;
  localparam int INV_W = 41;
  localparam int TW    = TKN_W + 2;
  localparam logic signed [TW-1:0] TMAXW = TW'(TEMP_MAX);
  localparam logic signed [TW-1:0] TMINW = TW'(TEMP_MIN);

  typedef struct packed {
    logic [35:0] num;
    logic [35:0] den;
    logic        sat;
    status_t     st;
    logic        ch;
  } sb_a_t;

  typedef struct packed {
    logic [38:0] inv_t0;
    logic        sat;
    status_t     st;
    logic        ch;
  } sb_b_t;

  typedef struct packed {
    logic [38:0] inv_t0;
    status_t     st;
    logic        ch;
  } sb_c_t;

  typedef struct packed {
    logic        neg;
    logic [38:0] inv_t0;
    status_t     st;
    logic        ch;
  } sb_d_t;

  typedef struct packed {
    logic    nonpos;
    status_t st;
    logic    ch;
  } sb_e_t;

  // ---------------------------------------------------------------- registers
  logic [13:0] beta_kelvin;
  logic [15:0] adc_full_scale;
  logic [15:0] zero_ck;
  logic [14:0] ref_tc;
  logic [19:0] nominal_ohms;
  logic [19:0] divider_ohms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_kelvin    <= BETA_RST;
      adc_full_scale <= FULL_RST;
      zero_ck        <= ZERO_CK_RST;
      ref_tc         <= REF_TC_RST;
      nominal_ohms   <= NOMINAL_RST;
      divider_ohms   <= DIVIDER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BETA:    beta_kelvin    <= cfg_data[13:0];
        CFG_FULL:    adc_full_scale <= cfg_data[15:0];
        CFG_ZERO_CK: zero_ck        <= cfg_data[15:0];
        CFG_REF_TC:  ref_tc         <= cfg_data[14:0];
        CFG_NOMINAL: nominal_ohms   <= cfg_data;
        CFG_DIVIDER: divider_ohms   <= cfg_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // zero values act as one
  logic [13:0] beta_eff;
  logic [19:0] nominal_eff;
  logic [16:0] t0_sum;
  logic [16:0] t0_eff;
  assign beta_eff    = (beta_kelvin == '0) ? 14'd1 : beta_kelvin;
  assign nominal_eff = (nominal_ohms == '0) ? 20'd1 : nominal_ohms;
  assign t0_sum      = 17'(zero_ck) + 17'(ref_tc);
  assign t0_eff      = (t0_sum == '0) ? 17'd1 : t0_sum;

  // Celsius offset follows the registers through off_x and off_prod; items
  // pass through far more registers than that to reach the output stage.
  logic [X_W-1:0]   off_x;
  logic [XP_W-1:0]  off_prod;
  logic [OFF_W-1:0] off_val;
  always_ff @(posedge clk) begin
    off_x    <= X_W'(32'(zero_ck) * 32'(TEMP_SCALE) + 32'd50);
    off_prod <= XP_W'(off_x) * XP_W'(RECIP100);
  end
  assign off_val = off_prod[XP_W-1:RECIP100_SHIFT];

  // ---------------------------------------------------------------- flow
  // Single pipeline enable: everything moves unless a finished result waits.
  logic en;
  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  // S1: capture beat
  logic        s1_valid;
  logic [15:0] s1_code;
  logic        s1_ch;

  // S2: divider numerator / denominator products, status
  logic        s2_valid;
  logic [35:0] s2_num;
  logic [35:0] s2_den;
  status_t     s2_st;
  logic        s2_ch;
  status_t     st_next;

  always_comb begin
    priority if (s1_code == '0) begin
      st_next = STATUS_OPEN;
    end else if (s1_code >= adc_full_scale) begin
      st_next = STATUS_FULL;
    end else begin
      st_next = STATUS_OK;
    end
  end

  // S3: ratio overflow check (q would exceed 32 bits)
  logic  s3_valid;
  sb_a_t s3_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= sample_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_code   <= adc_code;
      s1_ch     <= sensor_channel;
      s2_num    <= 36'(divider_ohms) * 36'(s1_code);
      s2_den    <= 36'(16'(adc_full_scale - s1_code)) * 36'(nominal_eff);
      s2_st     <= st_next;
      s2_ch     <= s1_ch;
      s3_sb.num <= s2_num;
      s3_sb.den <= s2_den;
      s3_sb.sat <= 36'(s2_num[35:16]) >= s2_den;
      s3_sb.st  <= s2_st;
      s3_sb.ch  <= s2_ch;
    end
  end

  // 1/T0 in Q0.32 per kelvin
  logic        a_valid;
  logic [38:0] inv_t0;
  sb_a_t       a_sb;

  thac_div #(
    .WD(39), .WV(17), .WQ(39), .WS($bits(sb_a_t))
  ) u_div_t0 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s3_valid),
    .dividend (INV_T0_NUM),
    .divisor  (t0_eff),
    .side_in  (s3_sb),
    .out_valid(a_valid),
    .quotient (inv_t0),
    .side_out (a_sb)
  );

  // resistance ratio, Q16.16
  sb_b_t       b_in;
  sb_b_t       b_sb;
  logic        b_valid;
  logic [31:0] ratio;
  logic [31:0] ratio_c;

  assign b_in.inv_t0 = inv_t0;
  assign b_in.sat    = a_sb.sat;
  assign b_in.st     = a_sb.st;
  assign b_in.ch     = a_sb.ch;

  thac_div #(
    .WD(52), .WV(36), .WQ(32), .WS($bits(sb_b_t))
  ) u_div_ratio (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (a_valid),
    .dividend ({a_sb.num, 16'b0}),
    .divisor  (a_sb.den),
    .side_in  (b_in),
    .out_valid(b_valid),
    .quotient (ratio),
    .side_out (b_sb)
  );

  // clamp to 1 .. 2^32-1
  assign ratio_c = b_sb.sat ? '1 : ((ratio == '0) ? 32'd1 : ratio);

  // ln(ratio)
  sb_c_t                  c_in;
  sb_c_t                  c_sb;
  logic                   c_valid;
  logic signed [LN_W-1:0] ln;

  assign c_in.inv_t0 = b_sb.inv_t0;
  assign c_in.st     = b_sb.st;
  assign c_in.ch     = b_sb.ch;

  thac_log #(
    .LN_TABLE_ENTRIES(LN_TABLE_ENTRIES), .WS($bits(sb_c_t))
  ) u_log (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (b_valid),
    .q        (ratio_c),
    .side_in  (c_in),
    .out_valid(c_valid),
    .ln       (ln),
    .side_out (c_sb)
  );

  // |ln| / beta, sign restored after the divide (truncation toward zero)
  logic [LN_W-1:0] ln_abs;
  sb_d_t           d_in;
  sb_d_t           d_sb;
  logic            d_valid;
  logic [35:0]     term;

  assign ln_abs      = ln[LN_W-1] ? LN_W'(-ln) : LN_W'(ln);
  assign d_in.neg    = ln[LN_W-1];
  assign d_in.inv_t0 = c_sb.inv_t0;
  assign d_in.st     = c_sb.st;
  assign d_in.ch     = c_sb.ch;

  thac_div #(
    .WD(36), .WV(14), .WQ(36), .WS($bits(sb_d_t))
  ) u_div_beta (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_valid),
    .dividend ({ln_abs[LN_W-2:0], 12'b0}),
    .divisor  (beta_eff),
    .side_in  (d_in),
    .out_valid(d_valid),
    .quotient (term),
    .side_out (d_sb)
  );

  // S6: 1/T = 1/T0 + ln/beta
  logic                    s6_valid;
  logic signed [INV_W-1:0] s6_inv;
  status_t                 s6_st;
  logic                    s6_ch;
  logic signed [INV_W-1:0] term_s;
  assign term_s = d_sb.neg ? -$signed(INV_W'(term)) : $signed(INV_W'(term));

  // S7: round-half-up reciprocal dividend
  logic             s7_valid;
  logic [TKN_W-1:0] s7_num;
  logic [IV_W-1:0]  s7_iv;
  sb_e_t            s7_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= d_valid;
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_inv       <= $signed(INV_W'(d_sb.inv_t0)) + term_s;
      s6_st        <= d_sb.st;
      s6_ch        <= d_sb.ch;
      s7_num       <= (TKN_W'(TEMP_SCALE) << 32) + TKN_W'(s6_inv[IV_W-1:1]);
      s7_iv        <= s6_inv[IV_W-1:0];
      s7_sb.nonpos <= s6_inv[INV_W-1] || (s6_inv == '0);
      s7_sb.st     <= s6_st;
      s7_sb.ch     <= s6_ch;
    end
  end

  // T * TEMP_SCALE in kelvin
  logic             e_valid;
  logic [TKN_W-1:0] tk;
  sb_e_t            e_sb;

  thac_div #(
    .WD(TKN_W), .WV(IV_W), .WQ(TKN_W), .WS($bits(sb_e_t))
  ) u_div_recip (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s7_valid),
    .dividend (s7_num),
    .divisor  (s7_iv),
    .side_in  (s7_sb),
    .out_valid(e_valid),
    .quotient (tk),
    .side_out (e_sb)
  );

  // output stage: Celsius, saturation, special codes
  logic signed [TW-1:0] t_full;
  logic signed [17:0]   temp_next;
  status_t              st_q;

  assign t_full = $signed(TW'(tk)) - $signed(TW'(off_val));

  always_comb begin
    priority if (e_sb.st == STATUS_OPEN) begin
      temp_next = TEMP_MAX;
    end else if (e_sb.st == STATUS_FULL) begin
      temp_next = TEMP_MIN;
    end else if (e_sb.nonpos) begin
      temp_next = TEMP_MAX;
    end else if (t_full > TMAXW) begin
      temp_next = TEMP_MAX;
    end else if (t_full < TMINW) begin
      temp_next = TEMP_MIN;
    end else begin
      temp_next = t_full[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp_scaled <= temp_next;
      out_channel <= e_sb.ch;
      st_q        <= e_sb.st;
    end
  end

  assign status = st_q;

  // ---------------------------------------------------------------- checks
  // a waiting result must hold off new samples
  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> sample_stall)
    else $error("sample accepted while result stalled");

  // a held result must not be overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(temp_scaled))
    else $error("stalled result changed");

  a_open: assert property (@(posedge clk) disable iff (rst)
    result_valid && (st_q == STATUS_OPEN) |-> temp_scaled == TEMP_MAX)
    else $error("open sensor not saturated high");

  a_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && (st_q == STATUS_FULL) |-> temp_scaled == TEMP_MIN)
    else $error("full-scale code not saturated low");

endmodule
